[hw/rtl/wavd_pkg.sv]
// Shared types, codes and constants for the WAV PCM16 stream decoder.
package wavd_pkg;

  // Input item: one file byte plus the end-of-file marker.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_FRAME  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_RIFF     = 3'd0,
    ERR_WAVE     = 3'd1,
    ERR_FMT      = 3'd2,
    ERR_NOT_PCM  = 3'd3,
    ERR_CHANNELS = 3'd4,
    ERR_DEPTH    = 3'd5,
    ERR_DATA_TAG = 3'd6,
    ERR_SHORT    = 3'd7
  } err_e;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_DONE   = 2'd2,
    PH_ERROR  = 2'd3
  } phase_e;

  // Result item.
  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [1:0]         channel_count;
    logic [31:0]        sample_rate;
    err_e               error_code;
    logic               last_frame;
    logic               last_of_run;
  } out_t;

  // Up to two results caused by one input item.
  typedef struct packed {
    out_t       first;
    out_t       second;
    logic [1:0] count;
  } res_pair_t;

  localparam logic [31:0] TagRiff     = 32'h4646_4952;
  localparam logic [31:0] TagWave     = 32'h4556_4157;
  localparam logic [31:0] TagFmt      = 32'h2074_6D66;
  localparam logic [31:0] TagData     = 32'h6174_6164;
  localparam logic [31:0] LowWordMask = 32'h0000_FFFF;
  localparam logic [15:0] Depth16     = 16'd16;

  // Header byte positions at which a check or capture happens.
  localparam logic [5:0] PosRiff   = 6'd3;
  localparam logic [5:0] PosWave   = 6'd11;
  localparam logic [5:0] PosFmt    = 6'd15;
  localparam logic [5:0] PosFormat = 6'd23;
  localparam logic [5:0] PosRate   = 6'd27;
  localparam logic [5:0] PosDepth  = 6'd35;
  localparam logic [5:0] PosData   = 6'd39;
  localparam logic [5:0] PosEnd    = 6'd43;

  localparam int FifoDepth = 4;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CountW    = PtrW + 1;

  function automatic out_t mk_error(err_e code);
    out_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

endpackage

[hw/rtl/wavd_parser.sv]
// Header checker and frame assembler: parser state and per-byte result pair.
module wavd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  wavd_pkg::in_t       item_i,
  output wavd_pkg::res_pair_t res_o
);
  import wavd_pkg::*;

  logic [5:0]  pos_q, pos_d;
  logic [31:0] hw_q, hw_d;
  logic [1:0]  ch_q, ch_d;
  logic [15:0] depth_q, depth_d;
  logic [31:0] rate_q, rate_d;
  logic [31:0] rem_q, rem_d;
  logic [1:0]  fidx_q, fidx_d;
  logic [23:0] part_q, part_d;
  phase_e      phase_q, phase_d;

  phase_e      phase_mid;
  logic [31:0] word;
  logic [7:0]  b;
  logic        v0;
  logic        short_err;
  logic        stereo;
  logic        done;
  out_t        res0;

  assign b    = item_i.data_byte;
  assign word = {b, hw_q[31:8]};

  always_comb begin
    pos_d     = pos_q;
    hw_d      = hw_q;
    ch_d      = ch_q;
    depth_d   = depth_q;
    rate_d    = rate_q;
    rem_d     = rem_q;
    fidx_d    = fidx_q;
    part_d    = part_q;
    phase_mid = phase_q;
    v0        = 1'b0;
    res0      = '0;
    stereo    = (ch_q == 2'd2);
    done      = 1'b0;

    case (phase_q)
      PH_HEADER: begin
        hw_d  = word;
        pos_d = pos_q + 6'd1;
        case (pos_q)
          PosRiff: begin
            if (word != TagRiff) begin
              v0 = 1'b1; res0 = mk_error(ERR_RIFF); phase_mid = PH_ERROR;
            end
          end
          PosWave: begin
            if (word != TagWave) begin
              v0 = 1'b1; res0 = mk_error(ERR_WAVE); phase_mid = PH_ERROR;
            end
          end
          PosFmt: begin
            if (word != TagFmt) begin
              v0 = 1'b1; res0 = mk_error(ERR_FMT); phase_mid = PH_ERROR;
            end
          end
          PosFormat: begin
            if ((word & LowWordMask) != 32'd1) begin
              v0 = 1'b1; res0 = mk_error(ERR_NOT_PCM); phase_mid = PH_ERROR;
            end else if (word[31:16] != 16'd1 && word[31:16] != 16'd2) begin
              v0 = 1'b1; res0 = mk_error(ERR_CHANNELS); phase_mid = PH_ERROR;
            end else begin
              ch_d = word[17:16];
            end
          end
          PosRate:  rate_d  = word;
          PosDepth: depth_d = word[31:16];
          PosData: begin
            if (word != TagData) begin
              v0 = 1'b1; res0 = mk_error(ERR_DATA_TAG); phase_mid = PH_ERROR;
            end
          end
          PosEnd: begin
            rem_d = word;
            if (depth_q != Depth16) begin
              v0 = 1'b1; res0 = mk_error(ERR_DEPTH); phase_mid = PH_ERROR;
            end else begin
              v0                 = 1'b1;
              res0.kind          = KIND_HEADER;
              res0.channel_count = ch_q;
              res0.sample_rate   = rate_q;
              fidx_d             = 2'd0;
              part_d             = '0;
              phase_mid          = (word == 32'd0) ? PH_DONE : PH_DATA;
            end
          end
          default: ;
        endcase
      end
      PH_DATA: begin
        rem_d = rem_q - 32'd1;
        done  = (rem_q == 32'd1);
        if (fidx_q == (stereo ? 2'd3 : 2'd1)) begin
          v0              = 1'b1;
          res0.kind       = KIND_FRAME;
          res0.last_frame = done;
          if (stereo) begin
            res0.left_sample  = part_q[15:0];
            res0.right_sample = {b, part_q[23:16]};
          end else begin
            res0.left_sample  = {b, part_q[7:0]};
          end
          fidx_d = 2'd0;
          part_d = '0;
        end else begin
          // Byte lanes above the current index are still zero.
          case (fidx_q)
            2'd0:    part_d[7:0]   = b;
            2'd1:    part_d[15:8]  = b;
            2'd2:    part_d[23:16] = b;
            default: ;
          endcase
          fidx_d = fidx_q + 2'd1;
        end
        if (done) begin
          phase_mid = PH_DONE;
        end
      end
      default: ;
    endcase

    short_err = item_i.stream_end && (phase_mid == PH_HEADER || phase_mid == PH_DATA);
    phase_d   = phase_mid;

    // End of file re-arms everything.
    if (item_i.stream_end) begin
      pos_d   = '0;
      hw_d    = '0;
      ch_d    = '0;
      depth_d = '0;
      rate_d  = '0;
      rem_d   = '0;
      fidx_d  = '0;
      part_d  = '0;
      phase_d = PH_HEADER;
    end
  end

  always_comb begin
    res_o.first  = v0 ? res0 : mk_error(ERR_SHORT);
    res_o.second = mk_error(ERR_SHORT);
    res_o.first.last_of_run  = !(v0 && short_err);
    res_o.second.last_of_run = 1'b1;
    res_o.count  = {1'b0, v0} + {1'b0, short_err};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      hw_q    <= '0;
      ch_q    <= '0;
      depth_q <= '0;
      rate_q  <= '0;
      rem_q   <= '0;
      fidx_q  <= '0;
      part_q  <= '0;
      phase_q <= PH_HEADER;
    end else if (take_i) begin
      pos_q   <= pos_d;
      hw_q    <= hw_d;
      ch_q    <= ch_d;
      depth_q <= depth_d;
      rate_q  <= rate_d;
      rem_q   <= rem_d;
      fidx_q  <= fidx_d;
      part_q  <= part_d;
      phase_q <= phase_d;
    end
  end

endmodule

[hw/rtl/wavd_result_fifo.sv]
// Small result queue: takes up to two results per cycle, delivers one.
module wavd_result_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  wavd_pkg::res_pair_t        pair_i,
  input  logic                       pop_i,
  output wavd_pkg::out_t             head_o,
  output logic [wavd_pkg::CountW-1:0] level_o
);
  import wavd_pkg::*;

  out_t              entries_q [FifoDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0] count_q, count_d;
  logic [1:0]        n_push;
  logic [PtrW-1:0]   wr_ptr_next;

  assign n_push      = push_i ? pair_i.count : 2'd0;
  assign wr_ptr_next = wr_ptr_q + PtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(n_push);
    rd_ptr_d = rd_ptr_q + PtrW'(pop_i);
    count_d  = count_q + CountW'(n_push) - CountW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      entries_q[wr_ptr_q] <= pair_i.first;
    end
    if (n_push == 2'd2) begin
      entries_q[wr_ptr_next] <= pair_i.second;
    end
  end

  assign head_o  = entries_q[rd_ptr_q];
  assign level_o = count_q;

endmodule

[hw/rtl/wav_pcm16_stream_decoder_top.sv]
// Top level of the WAV PCM16 stream decoder: parser plus result queue.
//
//   channel | dir | handshake                  | payload
//   --------+-----+----------------------------+-------------------------
//   in      | in  | in_valid_i / in_stall_o    | in_item_i  (byte, end)
//   out     | out | out_valid_o / out_stall_i  | out_item_o (result item)
//
// One byte is taken per cycle while not stalled; the parser updates its
// state on the accept edge and pushes 0, 1 or 2 results into a 4-entry
// queue that same edge. Results leave at one per cycle while out_stall_i
// is low, so the byte rate holds at 1 per cycle except on the rare bytes
// that cause two results (header end or frame with a short-stream error).
// in_stall_o rises when fewer than two queue slots are free; it depends
// only on registers. Reset clears parser state and empties the queue.
module wav_pcm16_stream_decoder_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  wavd_pkg::in_t    in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output wavd_pkg::out_t   out_item_o
);
  import wavd_pkg::*;

  logic              in_take;
  logic              out_take;
  res_pair_t         pair;
  logic [CountW-1:0] level;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_take = out_valid_o && !out_stall_i;

  // Room for a worst-case pair must exist before a byte is taken.
  assign in_stall_o  = (level > CountW'(FifoDepth - 2));
  assign out_valid_o = (level != '0);

  wavd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (in_take),
    .item_i (in_item_i),
    .res_o  (pair)
  );

  wavd_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_take),
    .pair_i  (pair),
    .pop_i   (out_take),
    .head_o  (out_item_o),
    .level_o (level)
  );

`ifndef ASSERT_OFF
  // Queue never overfills.
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= CountW'(FifoDepth))
    else $error("result queue overflow");

  // Input back-pressure only while results are pending.
  a_stall_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty queue");

  // An error is always the final result of its byte.
  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.kind == KIND_ERROR) |-> out_item_o.last_of_run)
    else $error("error result not last of run");
`endif

endmodule
